/* rtl/core/cvcs_pkg.sv */
// shared types and constants of the chassis velocity command shaper
package cvcs_pkg;

    // default command width in bits
    localparam int unsigned VEL_WIDTH_DEF = 24;

    // dial centre position
    localparam int unsigned DIAL_CENTRE = 1024;

    // frame modes
    localparam logic [1:0] MODE_KEYBOARD = 2'd0;
    localparam logic [1:0] MODE_SAFE     = 2'd1;
    localparam logic [1:0] MODE_DIAL     = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_TRANS_STEP   = 3'd0;
    localparam logic [2:0] CFG_TRANS_MAX    = 3'd1;
    localparam logic [2:0] CFG_ROT_STEP     = 3'd2;
    localparam logic [2:0] CFG_ROT_MAX      = 3'd3;
    localparam logic [2:0] CFG_YAW_DEADBAND = 3'd4;
    localparam logic [2:0] CFG_FOLLOW_GAIN  = 3'd5;

    // spin modes
    localparam logic [1:0] SPIN_FOLLOW = 2'd0;
    localparam logic [1:0] SPIN_CCW    = 2'd1;
    localparam logic [1:0] SPIN_CW     = 2'd2;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_SQL,
        S_SQT,
        S_SQM,
        S_CMP,
        S_SQRT,
        S_MUL_L,
        S_DIV_L,
        S_MUL_T,
        S_DIV_T,
        S_FOL,
        S_FIN
    } t_state;

endpackage

/* rtl/core/chassis_velocity_command_shaper_core.sv */
// chassis velocity command shaper: sequencer around one multiplier and one subtractor
//
// Input channel (i_valid / o_ready) carries one control frame per transaction:
// mode, six key levels, dial and gimbal yaw. Output channel (o_valid / i_ready)
// carries one result transaction per frame: three velocity commands and the
// safe stop flag. Configuration is a plain write port (i_cfg_we, i_cfg_idx,
// i_cfg_data); the user writes it only while the block is idle, which the
// block itself does not enforce. A frame is taken only in the idle state and
// then runs through a sequencer that reuses one multiplier and one subtractor.
// Safe, dial and unused modes pass through the decode, follow and final
// states to the result register. Keyboard frames pass through decode, three
// squaring states, a compare, follow and final; when the speed circle limit
// applies, the square root (two bits a cycle) and the two restoring divisions
// (one quotient bit a cycle) come between compare and follow. The next frame
// is accepted as soon as the sequencer is back in idle, even while a result
// still waits in the output register; if the receiver stalls with a result
// waiting, the sequencer holds the following result in its final state until
// the register frees. Reset clears the three velocity registers, spin mode,
// toggles and key history and loads the configuration defaults.
module chassis_velocity_command_shaper_core
    import cvcs_pkg::*;
#(
    parameter int unsigned VEL_WIDTH = VEL_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [2:0]                  i_cfg_idx,
    input  logic [22:0]                 i_cfg_data,
    // frame input
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_mode,
    input  logic                        i_key_fwd,
    input  logic                        i_key_back,
    input  logic                        i_key_left,
    input  logic                        i_key_right,
    input  logic                        i_key_ccw,
    input  logic                        i_key_cw,
    input  logic [10:0]                 i_dial,
    input  logic signed [15:0]          i_yaw_angle,
    // result output
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [VEL_WIDTH-1:0] o_vel_long,
    output logic signed [VEL_WIDTH-1:0] o_vel_lat,
    output logic signed [VEL_WIDTH-1:0] o_vel_rot,
    output logic                        o_safe_stop
);

    localparam int unsigned MW  = (VEL_WIDTH > 23) ? VEL_WIDTH : 23;
    localparam int unsigned EW  = MW + 2;
    localparam int unsigned SQW = 2 * MW + 2;
    localparam int unsigned SW  = MW + 5;
    localparam int unsigned CW  = $clog2(2 * MW);
    localparam logic signed [EW-1:0] VMAX = EW'((64'd1 << (VEL_WIDTH - 1)) - 64'd1);
    localparam logic signed [EW-1:0] VMIN = -VMAX - EW'(1);

    // saturate a wide signed value to the command width
    function automatic logic signed [VEL_WIDTH-1:0] f_sat(input logic signed [EW-1:0] v);
        logic signed [VEL_WIDTH-1:0] r;
        begin
            if (v > VMAX) r = VMAX[VEL_WIDTH-1:0];
            else if (v < VMIN) r = VMIN[VEL_WIDTH-1:0];
            else r = v[VEL_WIDTH-1:0];
            return r;
        end
    endfunction

    // configuration registers
    logic [15:0] r_trans_step, r_rot_step, r_follow_gain;
    logic [22:0] r_trans_max, r_rot_max;
    logic [14:0] r_yaw_deadband;

    // frame registers
    logic [1:0]         r_mode;
    logic               r_kf, r_kb, r_kl, r_kr, r_kq, r_ke;
    logic [10:0]        r_dial;
    logic signed [15:0] r_yaw;

    // persistent state
    logic signed [VEL_WIDTH-1:0] r_long, r_lat, r_rot;
    logic [1:0]                  r_spin;
    logic                        r_ccw_tg, r_cw_tg, r_ccw_prev, r_cw_prev;

    // sequencer and shared unit registers
    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt;
    logic [2*MW-1:0] r_prod;
    logic [SQW-1:0]  r_acc;
    logic [MW+1:0]   r_rem;
    logic [MW:0]     r_root;
    logic [2*MW-1:0] r_dvd;

    // output register
    logic r_o_valid;
    logic signed [VEL_WIDTH-1:0] r_o_long, r_o_lat, r_o_rot;
    logic r_o_safe;

    logic in_acc, fin_go;
    logic [VEL_WIDTH-1:0] abs_long, abs_lat;
    logic [MW-1:0] ml, mt, tm, ay;
    logic [MW-1:0] mul_a, mul_b;
    logic [2*MW-1:0] mul_p;
    logic [SW-1:0] sub_a, sub_b, sub_d;
    logic sub_borrow;
    logic sqrt_last, div_last;
    logic [2*MW-1:0] q_next;
    logic [VEL_WIDTH-1:0] q_val;

    assign in_acc   = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign fin_go   = !r_o_valid || i_ready;

    // magnitudes for the shared multiplier
    assign abs_long = r_long[VEL_WIDTH-1] ? VEL_WIDTH'(-r_long) : VEL_WIDTH'(r_long);
    assign abs_lat  = r_lat[VEL_WIDTH-1]  ? VEL_WIDTH'(-r_lat)  : VEL_WIDTH'(r_lat);
    assign ml = MW'(abs_long);
    assign mt = MW'(abs_lat);
    assign tm = MW'(r_trans_max);
    assign ay = r_yaw[15] ? MW'($unsigned(-r_yaw)) : MW'($unsigned(r_yaw));

    // shared multiplier operand selection
    always_comb begin
        mul_a = ml;
        mul_b = ml;
        case (r_state)
            S_SQT:   begin mul_a = mt;   mul_b = mt; end
            S_SQM:   begin mul_a = tm;   mul_b = tm; end
            S_MUL_L: begin mul_a = ml;   mul_b = tm; end
            S_MUL_T: begin mul_a = mt;   mul_b = tm; end
            S_FOL:   begin mul_a = ay;   mul_b = MW'(r_follow_gain); end
            default: begin mul_a = ml;   mul_b = ml; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // shared subtractor: square root trial or division step
    always_comb begin
        if (r_state == S_SQRT) begin
            sub_a = SW'({r_rem, r_acc[SQW-1 -: 2]});
            sub_b = SW'({r_root, 2'b01});
        end else begin
            sub_a = SW'({r_rem[MW:0], r_dvd[2*MW-1]});
            sub_b = SW'(r_root);
        end
    end
    assign sub_d      = sub_a - sub_b;
    assign sub_borrow = sub_d[SW-1];
    assign sqrt_last  = (r_cnt == CW'(MW));
    assign div_last   = (r_cnt == CW'(2 * MW - 1));
    assign q_next     = {r_dvd[2*MW-2:0], !sub_borrow};
    assign q_val      = q_next[VEL_WIDTH-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_acc) n_state = S_DEC;
            S_DEC: begin
                if (r_mode == MODE_KEYBOARD) n_state = S_SQL;
                else n_state = S_FOL;
            end
            S_SQL:   n_state = S_SQT;
            S_SQT:   n_state = S_SQM;
            S_SQM:   n_state = S_CMP;
            S_CMP:   n_state = (r_acc > SQW'(r_prod)) ? S_SQRT : S_FOL;
            S_SQRT:  if (sqrt_last) n_state = S_MUL_L;
            S_MUL_L: n_state = S_DIV_L;
            S_DIV_L: if (div_last) n_state = S_MUL_T;
            S_MUL_T: n_state = S_DIV_T;
            S_DIV_T: if (div_last) n_state = S_FOL;
            S_FOL:   n_state = S_FIN;
            S_FIN:   if (fin_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trans_step   <= 16'd256;
            r_trans_max    <= 23'd65536;
            r_rot_step     <= 16'd256;
            r_rot_max      <= 23'd65536;
            r_yaw_deadband <= 15'd41;
            r_follow_gain  <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TRANS_STEP:   r_trans_step   <= i_cfg_data[15:0];
                CFG_TRANS_MAX:    r_trans_max    <= i_cfg_data;
                CFG_ROT_STEP:     r_rot_step     <= i_cfg_data[15:0];
                CFG_ROT_MAX:      r_rot_max      <= i_cfg_data;
                CFG_YAW_DEADBAND: r_yaw_deadband <= i_cfg_data[14:0];
                CFG_FOLLOW_GAIN:  r_follow_gain  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // frame capture
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode <= i_mode;
            r_kf   <= i_key_fwd;
            r_kb   <= i_key_back;
            r_kl   <= i_key_left;
            r_kr   <= i_key_right;
            r_kq   <= i_key_ccw;
            r_ke   <= i_key_cw;
            r_dial <= i_dial;
            r_yaw  <= i_yaw_angle;
        end
    end

    // translational ramp of one axis
    function automatic logic signed [VEL_WIDTH-1:0] f_ramp(
        input logic signed [VEL_WIDTH-1:0] v,
        input logic plus,
        input logic minus,
        input logic [22:0] tmax,
        input logic [15:0] step
    );
        logic signed [EW-1:0] ve, te, se;
        logic signed [VEL_WIDTH-1:0] r;
        begin
            ve = EW'(v);
            te = EW'(tmax);
            se = EW'(step);
            if (plus == minus) r = '0;
            else if (plus && (ve < te)) r = f_sat(ve + se);
            else if (minus && (ve > -te)) r = f_sat(ve - se);
            else r = v;
            return r;
        end
    endfunction

    // rotation, toggles and result values of the final step
    logic signed [EW-1:0]        fol_m, spin_s, rmax_e, dial_e;
    logic signed [VEL_WIDTH-1:0] fol_v, spin_v, rot_n;
    logic signed [11:0]          dial_off;
    logic                        ccw_n, cw_n;
    logic [1:0]                  spin_n;

    always_comb begin
        fol_m = EW'(r_prod[31:12]);
        if (ay < MW'(r_yaw_deadband)) fol_v = '0;
        else fol_v = f_sat(r_yaw[15] ? fol_m : -fol_m);
        rmax_e   = EW'(r_rot_max);
        dial_off = 12'(r_dial) - 12'(DIAL_CENTRE);
        dial_e   = EW'(dial_off) <<< 8;
        ccw_n    = r_ccw_tg ^ (r_ccw_prev && !r_kq);
        cw_n     = r_cw_tg ^ (r_cw_prev && !r_ke);
        spin_n   = r_spin;
        spin_s   = '0;
        spin_v   = r_rot;
        rot_n    = r_rot;
        case (r_mode)
            MODE_KEYBOARD: begin
                case (r_spin)
                    SPIN_FOLLOW: begin
                        rot_n = fol_v;
                        if (ccw_n) spin_n = SPIN_CCW;
                        else if (cw_n) spin_n = SPIN_CW;
                    end
                    SPIN_CCW: begin
                        spin_s = EW'(r_rot) + EW'(r_rot_step);
                        spin_v = f_sat(spin_s);
                        if (EW'(spin_v) > rmax_e) spin_v = f_sat(rmax_e);
                        rot_n = spin_v;
                        if (!ccw_n) spin_n = SPIN_FOLLOW;
                        if (cw_n) begin
                            spin_n = SPIN_CW;
                            ccw_n  = 1'b0;
                        end
                    end
                    SPIN_CW: begin
                        spin_s = EW'(r_rot) - EW'(r_rot_step);
                        spin_v = f_sat(spin_s);
                        if (EW'(spin_v) < -rmax_e) spin_v = f_sat(-rmax_e);
                        rot_n = spin_v;
                        if (!cw_n) spin_n = SPIN_FOLLOW;
                        if (ccw_n) begin
                            spin_n = SPIN_CCW;
                            cw_n   = 1'b0;
                        end
                    end
                    default: spin_n = SPIN_FOLLOW;
                endcase
            end
            MODE_DIAL: begin
                if (r_dial == '0) rot_n = '0;
                else if (r_dial == 11'(DIAL_CENTRE)) rot_n = fol_v;
                else rot_n = f_sat(dial_e);
            end
            MODE_SAFE: rot_n = '0;
            default: rot_n = r_rot;
        endcase
    end

    // datapath of the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long     <= '0;
            r_lat      <= '0;
            r_rot      <= '0;
            r_spin     <= SPIN_FOLLOW;
            r_ccw_tg   <= 1'b0;
            r_cw_tg    <= 1'b0;
            r_ccw_prev <= 1'b0;
            r_cw_prev  <= 1'b0;
            r_cnt      <= '0;
        end else begin
            case (r_state)
                S_DEC: begin
                    if (r_mode == MODE_KEYBOARD) begin
                        r_long <= f_ramp(r_long, r_kf, r_kb, r_trans_max, r_trans_step);
                        r_lat  <= f_ramp(r_lat, r_kl, r_kr, r_trans_max, r_trans_step);
                    end
                end
                S_SQL: r_prod <= mul_p;
                S_SQT: begin
                    r_acc  <= SQW'(r_prod);
                    r_prod <= mul_p;
                end
                S_SQM: begin
                    r_acc  <= r_acc + SQW'(r_prod);
                    r_prod <= mul_p;
                end
                S_CMP: begin
                    r_rem  <= '0;
                    r_root <= '0;
                    r_cnt  <= '0;
                end
                S_SQRT: begin
                    r_acc <= {r_acc[SQW-3:0], 2'b00};
                    if (!sub_borrow) begin
                        r_rem  <= sub_d[MW+1:0];
                        r_root <= {r_root[MW-1:0], 1'b1};
                    end else begin
                        r_rem  <= sub_a[MW+1:0];
                        r_root <= {r_root[MW-1:0], 1'b0};
                    end
                    // a zero root is taken as one for the divisions
                    if (sqrt_last && (r_root[MW-1:0] == '0) && sub_borrow)
                        r_root <= (MW + 1)'(1);
                    r_cnt <= r_cnt + CW'(1);
                end
                S_MUL_L, S_MUL_T: begin
                    r_dvd <= mul_p;
                    r_rem <= '0;
                    r_cnt <= '0;
                end
                S_DIV_L, S_DIV_T: begin
                    r_dvd <= q_next;
                    if (!sub_borrow) r_rem <= sub_d[MW+1:0];
                    else r_rem <= sub_a[MW+1:0];
                    r_cnt <= r_cnt + CW'(1);
                    if (div_last) begin
                        if (r_state == S_DIV_L)
                            r_long <= r_long[VEL_WIDTH-1] ? VEL_WIDTH'(-q_val) : q_val;
                        else
                            r_lat <= r_lat[VEL_WIDTH-1] ? VEL_WIDTH'(-q_val) : q_val;
                    end
                end
                S_FOL: r_prod <= mul_p;
                S_FIN: begin
                    if (fin_go) begin
                        r_rot <= rot_n;
                        if (r_mode == MODE_KEYBOARD) begin
                            r_spin     <= spin_n;
                            r_ccw_tg   <= ccw_n;
                            r_cw_tg    <= cw_n;
                            r_ccw_prev <= r_kq;
                            r_cw_prev  <= r_ke;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            if (r_state == S_FIN && fin_go) r_o_valid <= 1'b1;
            else if (i_ready) r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && fin_go) begin
            r_o_long <= (r_mode == MODE_KEYBOARD) ? r_long : '0;
            r_o_lat  <= (r_mode == MODE_KEYBOARD) ? r_lat : '0;
            r_o_rot  <= (r_mode == MODE_KEYBOARD || r_mode == MODE_DIAL) ? rot_n : '0;
            r_o_safe <= (r_mode == MODE_SAFE);
        end
    end

    assign o_valid     = r_o_valid;
    assign o_vel_long  = r_o_long;
    assign o_vel_lat   = r_o_lat;
    assign o_vel_rot   = r_o_rot;
    assign o_safe_stop = r_o_safe;

`ifndef ASSERT_OFF
    // a frame transaction starts the sequencer, so no second frame is taken next cycle
    a_one_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_ready)
        else $error("frame accepted while sequencer busy");

    // divisions never see a zero divisor
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_L || r_state == S_DIV_T) |-> (r_root != '0))
        else $error("zero divisor in circle limit");

    // safe stop results carry no motion
    a_safe_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_safe_stop) |-> (o_vel_long == '0 && o_vel_lat == '0 &&
                                      o_vel_rot == '0))
        else $error("motion in safe stop result");

    // spin mode stays within its three codes
    a_spin_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_spin != 2'd3)
        else $error("invalid spin mode");
`endif

endmodule
